>>> design/pf_pkg.sv
// shared types and constants for the playfair digraph cipher
package pf_pkg;

    localparam int LETTER_W    = 5;
    localparam int SIDE        = 5;
    localparam int CELL_NUM    = SIDE * SIDE;
    localparam int SQUARE_W    = CELL_NUM * LETTER_W;
    localparam int POS_W       = 3;
    localparam int CFG_W       = 50;
    localparam int CFG_IDX_W   = 2;
    localparam int UPPER_W     = 2 * SIDE * LETTER_W;
    localparam int BOTTOM_W    = SIDE * LETTER_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W     = 8;

    localparam logic [LETTER_W-1:0] LET_I = 5'd8;
    localparam logic [LETTER_W-1:0] LET_J = 5'd9;
    localparam logic [LETTER_W-1:0] LET_X = 5'd23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION  = 2'd0,
        CFG_KEY_UPPER  = 2'd1,
        CFG_KEY_MIDDLE = 2'd2,
        CFG_KEY_BOTTOM = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
        logic                dec;
        logic                odd;
        logic                last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> design/pf_front.sv
// front end: letter pairing, padding and pair job generation
module pf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [pf_pkg::TDATA_W-1:0] s_tdata,   // [4:0] letter_in
    input  logic                 s_tlast,
    input  logic                 direction,
    input  pf_pkg::queue_status_t q_status,
    output logic                 push,
    output pf_pkg::job_t         push_job
);

    logic [pf_pkg::LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                        held_valid_reg, held_valid_next;
    logic                        pend_valid_reg, pend_valid_next;
    pf_pkg::job_t                pend_job_reg, pend_job_next;
    logic [pf_pkg::LETTER_W-1:0] letter;
    logic                        accept;
    logic                        j1_valid;
    logic                        j2_valid;
    pf_pkg::job_t                j1;
    pf_pkg::job_t                j2;

    assign s_tready = !pend_valid_reg && !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        letter = s_tdata[pf_pkg::LETTER_W-1:0];
        if (!direction && letter == pf_pkg::LET_J)
        begin
            letter = pf_pkg::LET_I;
        end
    end

    always_comb
    begin
        j1       = '{a: held_letter_reg, b: letter, dec: direction, odd: 1'b0, last: 1'b1};
        j2       = '{a: letter, b: pf_pkg::LET_X, dec: 1'b0, odd: 1'b0, last: 1'b1};
        j1_valid = 1'b0;
        j2_valid = 1'b0;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        if (!direction)
        begin
            if (held_valid_reg)
            begin
                j1_valid = 1'b1;
                if (held_letter_reg == letter)
                begin
                    // doubled pair: pad the held letter, keep the new one
                    j1.b             = pf_pkg::LET_X;
                    j1.last          = !s_tlast;
                    j2_valid         = s_tlast;
                    held_letter_next = letter;
                    held_valid_next  = !s_tlast;
                end
                else
                begin
                    held_valid_next = 1'b0;
                end
            end
            else if (s_tlast)
            begin
                j1_valid = 1'b1;
                j1.a     = letter;
                j1.b     = pf_pkg::LET_X;
            end
            else
            begin
                held_letter_next = letter;
                held_valid_next  = 1'b1;
            end
        end
        else
        begin
            if (held_valid_reg)
            begin
                j1_valid        = 1'b1;
                held_valid_next = 1'b0;
            end
            else if (s_tlast)
            begin
                j1_valid = 1'b1;
                j1.a     = letter;
                j1.odd   = 1'b1;
            end
            else
            begin
                held_letter_next = letter;
                held_valid_next  = 1'b1;
            end
        end
        if (s_tlast)
        begin
            held_valid_next = 1'b0;
        end
    end

    assign push     = (accept && j1_valid) || (pend_valid_reg && !q_status.full);
    assign push_job = pend_valid_reg ? pend_job_reg : j1;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        if (pend_valid_reg && !q_status.full)
        begin
            pend_valid_next = 1'b0;
        end
        if (accept && j2_valid)
        begin
            pend_valid_next = 1'b1;
            pend_job_next   = j2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                held_letter_reg <= held_letter_next;
                held_valid_reg  <= held_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_job_reg <= pend_job_next;
    end

    // the pending job only comes from a doubled final pair in encrypt mode
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_job_reg.last && !pend_job_reg.dec && !pend_job_reg.odd))
        else $error("pending job has unexpected flags");

endmodule

>>> design/pf_queue.sv
// short job queue between the front end and the substitution back end
module pf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pf_pkg::job_t          push_job,
    input  logic                  pop,
    output pf_pkg::job_t          pop_job,
    output pf_pkg::queue_status_t status
);

    pf_pkg::job_t              slot_reg [pf_pkg::QUEUE_DEPTH];
    logic [pf_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pf_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pf_pkg::QPTR_W:0]   count_reg;

    assign status.full  = (count_reg == (pf_pkg::QPTR_W+1)'(pf_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

>>> design/pf_back.sv
// back end: square lookup, substitution rules and output beats
module pf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pf_pkg::SQUARE_W-1:0]   square,
    input  pf_pkg::queue_status_t         q_status,
    input  pf_pkg::job_t                  pop_job,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pf_pkg::TDATA_W-1:0]    m_tdata,   // [4:0] letter_out
    output logic                          m_tlast,
    output logic [1:0]                    m_tuser    // [0] not_in_square, [1] odd_tail
);

    localparam int BASE_W = $clog2(pf_pkg::SQUARE_W);

    typedef struct packed {
        logic                     hit;
        logic [pf_pkg::POS_W-1:0] row;
        logic [pf_pkg::POS_W-1:0] col;
    } loc_t;

    function automatic loc_t locate(input logic [pf_pkg::SQUARE_W-1:0] sq,
                                    input logic [pf_pkg::LETTER_W-1:0] code);
        loc_t loc;
        loc = '0;
        // later cells win on duplicates
        for (int r = 0; r < pf_pkg::SIDE; r++)
        begin
            for (int c = 0; c < pf_pkg::SIDE; c++)
            begin
                if (sq[(r*pf_pkg::SIDE+c)*pf_pkg::LETTER_W +: pf_pkg::LETTER_W] == code)
                begin
                    loc.hit = 1'b1;
                    loc.row = pf_pkg::POS_W'(r);
                    loc.col = pf_pkg::POS_W'(c);
                end
            end
        end
        return loc;
    endfunction

    function automatic logic [pf_pkg::LETTER_W-1:0] cell_at(
        input logic [pf_pkg::SQUARE_W-1:0] sq,
        input logic [pf_pkg::POS_W-1:0]    row,
        input logic [pf_pkg::POS_W-1:0]    col);
        logic [BASE_W-1:0] base;
        base = BASE_W'(row) * BASE_W'(pf_pkg::SIDE * pf_pkg::LETTER_W)
             + BASE_W'(col) * BASE_W'(pf_pkg::LETTER_W);
        return sq[base +: pf_pkg::LETTER_W];
    endfunction

    function automatic logic [pf_pkg::POS_W-1:0] shift_pos(
        input logic [pf_pkg::POS_W-1:0] pos,
        input logic                     dec);
        logic [pf_pkg::POS_W-1:0] res;
        if (dec)
        begin
            res = (pos == '0) ? pf_pkg::POS_W'(pf_pkg::SIDE - 1) : pos - 1'b1;
        end
        else
        begin
            res = (pos == pf_pkg::POS_W'(pf_pkg::SIDE - 1)) ? '0 : pos + 1'b1;
        end
        return res;
    endfunction

    logic                        s1_valid_reg;
    pf_pkg::job_t                s1_job_reg;
    loc_t                        s1_loc_a_reg;
    loc_t                        s1_loc_b_reg;
    logic                        out_valid_reg;
    logic                        rem_reg;
    logic [pf_pkg::LETTER_W-1:0] cur_reg;
    logic [pf_pkg::LETTER_W-1:0] nxt_reg;
    logic                        nis_reg;
    logic                        odd_reg;
    logic                        last_reg;
    logic                        s2_free;
    logic                        s2_load;
    logic [pf_pkg::LETTER_W-1:0] first_next;
    logic [pf_pkg::LETTER_W-1:0] second_next;
    logic                        nis_next;

    assign s2_free = !out_valid_reg || (m_tready && !rem_reg);
    assign s2_load = s1_valid_reg && s2_free;
    assign pop     = !q_status.empty && (!s1_valid_reg || s2_free);

    always_comb
    begin
        first_next  = s1_job_reg.a;
        second_next = s1_job_reg.b;
        nis_next    = 1'b0;
        if (s1_job_reg.odd)
        begin
            second_next = s1_job_reg.a;
        end
        else if (!(s1_loc_a_reg.hit && s1_loc_b_reg.hit))
        begin
            nis_next = 1'b1;
        end
        else if (s1_loc_a_reg.row == s1_loc_b_reg.row)
        begin
            first_next  = cell_at(square, s1_loc_a_reg.row,
                                  shift_pos(s1_loc_a_reg.col, s1_job_reg.dec));
            second_next = cell_at(square, s1_loc_b_reg.row,
                                  shift_pos(s1_loc_b_reg.col, s1_job_reg.dec));
        end
        else if (s1_loc_a_reg.col == s1_loc_b_reg.col)
        begin
            first_next  = cell_at(square, shift_pos(s1_loc_a_reg.row, s1_job_reg.dec),
                                  s1_loc_a_reg.col);
            second_next = cell_at(square, shift_pos(s1_loc_b_reg.row, s1_job_reg.dec),
                                  s1_loc_b_reg.col);
        end
        else
        begin
            first_next  = cell_at(square, s1_loc_a_reg.row, s1_loc_b_reg.col);
            second_next = cell_at(square, s1_loc_b_reg.row, s1_loc_a_reg.col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
                rem_reg       <= !s1_job_reg.odd;
            end
            else if (out_valid_reg && m_tready)
            begin
                if (rem_reg)
                begin
                    rem_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_job_reg   <= pop_job;
            s1_loc_a_reg <= locate(square, pop_job.a);
            s1_loc_b_reg <= locate(square, pop_job.b);
        end
        if (s2_load)
        begin
            cur_reg  <= first_next;
            nxt_reg  <= second_next;
            nis_reg  <= nis_next;
            odd_reg  <= s1_job_reg.odd;
            last_reg <= s1_job_reg.last;
        end
        else if (out_valid_reg && m_tready && rem_reg)
        begin
            cur_reg <= nxt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(pf_pkg::TDATA_W - pf_pkg::LETTER_W)'(0), cur_reg};
    assign m_tlast  = last_reg && !rem_reg;
    assign m_tuser  = {odd_reg, nis_reg};

    // a lone decrypt tail is a single beat with no lookup flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && odd_reg) |-> (!rem_reg && !nis_reg))
        else $error("odd tail beat malformed");

endmodule

>>> design/playfair_digraph_cipher.sv
// top level of the playfair digraph cipher: config registers, front end, queue, back end
// throughput: one output beat per cycle while m_tready is high and two beats per pair job,
//   so one letter per cycle on plain pairs and two beats per letter when encrypt padding
//   gives each letter its own pair
// a doubled final pair in encrypt mode gives two pair jobs and four beats
// reset: direction is encrypt, square is all zero, no letter held, queue empty
module playfair_digraph_cipher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pf_pkg::TDATA_W-1:0]    s_tdata,   // [4:0] letter_in
    input  logic                          s_tlast,   // final_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pf_pkg::TDATA_W-1:0]    m_tdata,   // [4:0] letter_out
    output logic                          m_tlast,   // final_out
    output logic [1:0]                    m_tuser,   // [0] not_in_square, [1] odd_tail
    input  logic                          cfg_we,
    input  logic [pf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pf_pkg::CFG_W-1:0]      cfg_data
);

    logic                          direction_reg;
    logic [pf_pkg::UPPER_W-1:0]    key_upper_reg;
    logic [pf_pkg::UPPER_W-1:0]    key_middle_reg;
    logic [pf_pkg::BOTTOM_W-1:0]   key_bottom_reg;
    logic [pf_pkg::SQUARE_W-1:0]   square;
    pf_pkg::queue_status_t         q_status;
    logic                          push;
    logic                          pop;
    pf_pkg::job_t                  push_job;
    pf_pkg::job_t                  pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= 1'b0;
            key_upper_reg  <= '0;
            key_middle_reg <= '0;
            key_bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pf_pkg::cfg_index_t'(cfg_index))
                pf_pkg::CFG_DIRECTION:  direction_reg  <= cfg_data[0];
                pf_pkg::CFG_KEY_UPPER:  key_upper_reg  <= cfg_data[pf_pkg::UPPER_W-1:0];
                pf_pkg::CFG_KEY_MIDDLE: key_middle_reg <= cfg_data[pf_pkg::UPPER_W-1:0];
                pf_pkg::CFG_KEY_BOTTOM: key_bottom_reg <= cfg_data[pf_pkg::BOTTOM_W-1:0];
                default:                direction_reg  <= direction_reg;
            endcase
        end
    end

    // cells in row-major order, cell 0 in the lowest bits
    assign square = {key_bottom_reg, key_middle_reg, key_upper_reg};

    pf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .direction (direction_reg),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    pf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    pf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .square   (square),
        .q_status (q_status),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the playfair digraph cipher
module tb_top;

    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 185;

    typedef struct packed {
        logic [pf_pkg::LETTER_W-1:0] letter;
        logic                        last;
        logic                        nis;
        logic                        odd;
    } beat_t;

    typedef struct packed {
        logic                        is_write;
        pf_pkg::cfg_index_t          reg_sel;
        logic [pf_pkg::CFG_W-1:0]    value;
        logic [pf_pkg::LETTER_W-1:0] letter;
        logic                        fin;
        logic [2:0]                  n_typed;
        beat_t                       typed1;
        beat_t                       typed0;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [pf_pkg::TDATA_W-1:0]   s_tdata   = '0;
    logic                         s_tlast   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [pf_pkg::TDATA_W-1:0]   m_tdata;
    logic                         m_tlast;
    logic [1:0]                   m_tuser;
    logic                         cfg_we    = 1'b0;
    logic [pf_pkg::CFG_IDX_W-1:0] cfg_index = pf_pkg::CFG_DIRECTION;
    logic [pf_pkg::CFG_W-1:0]     cfg_data  = '0;

    // shadow of the block
    logic [pf_pkg::LETTER_W-1:0] square [pf_pkg::CELL_NUM];
    logic                        decrypt = 1'b0;
    logic [pf_pkg::LETTER_W-1:0] held    = '0;
    logic                        held_ok = 1'b0;

    logic [pf_pkg::LETTER_W-1:0] key_cells [pf_pkg::CELL_NUM];
    beat_t                       fresh_beats [$];
    beat_t                       expected_beats [$];
    stim_row_t                   directed_rows [$];
    int                          mismatches = 0;
    int                          burst_left = 0;
    bit                          sending    = 1'b0;

    playfair_digraph_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** playfair_digraph_cipher: FAILED **");
        $finish;
    end

    function automatic beat_t make_beat(input logic [pf_pkg::LETTER_W-1:0] letter,
                                        input logic last, input logic nis, input logic odd);
        beat_t b;
        b.letter = letter;
        b.last   = last;
        b.nis    = nis;
        b.odd    = odd;
        return b;
    endfunction

    // last match in row-major order wins
    function automatic bit find_cell(input logic [pf_pkg::LETTER_W-1:0] c, output int row,
                                     output int col);
        bit hit;
        int k;
        hit = 1'b0;
        row = 0;
        col = 0;
        for (k = 0; k < pf_pkg::CELL_NUM; k++)
        begin
            if (square[k] == c)
            begin
                row = k / pf_pkg::SIDE;
                col = k % pf_pkg::SIDE;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic cipher_pair(input logic [pf_pkg::LETTER_W-1:0] a,
                               input logic [pf_pkg::LETTER_W-1:0] b, input bit dec);
        int r1, c1, r2, c2, step, side;
        bit fa, fb;
        side = pf_pkg::SIDE;
        step = dec ? side - 1 : 1;
        fa = find_cell(a, r1, c1);
        fb = find_cell(b, r2, c2);
        if (!fa || !fb)
        begin
            fresh_beats.push_back(make_beat(a, 1'b0, 1'b1, 1'b0));
            fresh_beats.push_back(make_beat(b, 1'b0, 1'b1, 1'b0));
        end
        else if (r1 == r2)
        begin
            fresh_beats.push_back(make_beat(square[r1*side + (c1+step)%side], 1'b0, 1'b0, 1'b0));
            fresh_beats.push_back(make_beat(square[r2*side + (c2+step)%side], 1'b0, 1'b0, 1'b0));
        end
        else if (c1 == c2)
        begin
            fresh_beats.push_back(make_beat(square[((r1+step)%side)*side + c1], 1'b0, 1'b0, 1'b0));
            fresh_beats.push_back(make_beat(square[((r2+step)%side)*side + c2], 1'b0, 1'b0, 1'b0));
        end
        else
        begin
            fresh_beats.push_back(make_beat(square[r1*side + c2], 1'b0, 1'b0, 1'b0));
            fresh_beats.push_back(make_beat(square[r2*side + c1], 1'b0, 1'b0, 1'b0));
        end
    endtask

    task automatic playfair_step(input logic [pf_pkg::LETTER_W-1:0] letter, input logic fin);
        logic [pf_pkg::LETTER_W-1:0] l;
        beat_t b;
        l = letter;
        fresh_beats.delete();
        if (!decrypt)
        begin
            if (l == pf_pkg::LET_J)
                l = pf_pkg::LET_I;
            if (held_ok)
            begin
                if (held == l)
                begin
                    cipher_pair(held, pf_pkg::LET_X, 1'b0);
                    if (fin)
                        cipher_pair(l, pf_pkg::LET_X, 1'b0);
                    held    = l;
                    held_ok = !fin;
                end
                else
                begin
                    cipher_pair(held, l, 1'b0);
                    held_ok = 1'b0;
                end
            end
            else if (fin)
                cipher_pair(l, pf_pkg::LET_X, 1'b0);
            else
            begin
                held    = l;
                held_ok = 1'b1;
            end
        end
        else
        begin
            if (held_ok)
            begin
                cipher_pair(held, l, 1'b1);
                held_ok = 1'b0;
            end
            else if (fin)
                fresh_beats.push_back(make_beat(l, 1'b0, 1'b0, 1'b1));
            else
            begin
                held    = l;
                held_ok = 1'b1;
            end
        end
        if (fin)
            held_ok = 1'b0;
        if (fresh_beats.size() > 0)
        begin
            b = fresh_beats.pop_back();
            b.last = 1'b1;
            fresh_beats.push_back(b);
        end
    endtask

    function automatic logic [pf_pkg::CFG_W-1:0] pack_cells(input int first, input int count);
        logic [pf_pkg::CFG_W-1:0] v;
        int k;
        v = '0;
        for (k = 0; k < count; k++)
            v[pf_pkg::LETTER_W*k +: pf_pkg::LETTER_W] = key_cells[first + k];
        return v;
    endfunction

    task automatic shuffle_key(input logic [pf_pkg::LETTER_W-1:0] dropped);
        int n, c, k, pick;
        logic [pf_pkg::LETTER_W-1:0] t;
        n = 0;
        for (c = 0; c < 26; c++)
        begin
            if (c != dropped)
            begin
                key_cells[n] = pf_pkg::LETTER_W'(c);
                n++;
            end
        end
        for (k = pf_pkg::CELL_NUM - 1; k > 0; k--)
        begin
            pick = $urandom_range(0, k);
            t = key_cells[k];
            key_cells[k] = key_cells[pick];
            key_cells[pick] = t;
        end
    endtask

    task automatic hold_off();
        if (sending)
        begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end
        burst_left = 0;
    endtask

    task automatic wait_idle();
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input pf_pkg::cfg_index_t sel,
                             input logic [pf_pkg::CFG_W-1:0] value);
        int k;
        hold_off();
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            pf_pkg::CFG_DIRECTION:
                decrypt = value[0];
            pf_pkg::CFG_KEY_UPPER:
                for (k = 0; k < 10; k++)
                    square[k] = value[pf_pkg::LETTER_W*k +: pf_pkg::LETTER_W];
            pf_pkg::CFG_KEY_MIDDLE:
                for (k = 0; k < 10; k++)
                    square[10+k] = value[pf_pkg::LETTER_W*k +: pf_pkg::LETTER_W];
            pf_pkg::CFG_KEY_BOTTOM:
                for (k = 0; k < 5; k++)
                    square[20+k] = value[pf_pkg::LETTER_W*k +: pf_pkg::LETTER_W];
            default: ;
        endcase
    endtask

    task automatic send_letter(input logic [pf_pkg::LETTER_W-1:0] letter, input logic fin,
                               input int n_typed, input beat_t t0, input beat_t t1);
        if (!sending)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(pf_pkg::TDATA_W-pf_pkg::LETTER_W){1'b0}}, letter};
        s_tlast  <= fin;
        sending = 1'b1;
        do @(posedge clk); while (!s_tready);
        playfair_step(letter, fin);
        if (n_typed != 0)
        begin
            expected_beats.push_back(t0);
            if (n_typed > 1)
                expected_beats.push_back(t1);
        end
        else
        begin
            foreach (fresh_beats[i])
                expected_beats.push_back(fresh_beats[i]);
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    task automatic add_write(input pf_pkg::cfg_index_t sel,
                             input logic [pf_pkg::CFG_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_sel  = sel;
        row.value    = value;
        directed_rows.push_back(row);
    endtask

    task automatic add_letter(input logic [pf_pkg::LETTER_W-1:0] letter, input logic fin,
                              input int n = 0, input beat_t t0 = '0, input beat_t t1 = '0);
        stim_row_t row;
        row = '0;
        row.letter  = letter;
        row.fin     = fin;
        row.n_typed = 3'(n);
        row.typed0  = t0;
        row.typed1  = t1;
        directed_rows.push_back(row);
    endtask

    task automatic check_beat();
        beat_t got, want;
        got = make_beat(m_tdata[pf_pkg::LETTER_W-1:0], m_tlast, m_tuser[0], m_tuser[1]);
        if (expected_beats.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected beat: letter=%0d last=%0d nis=%0d odd=%0d",
                         got.letter, got.last, got.nis, got.odd);
            mismatches++;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("beat mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.letter, want.last, want.nis, want.odd,
                             got.letter, got.last, got.nis, got.odd);
                mismatches++;
            end
        end
    endtask

    // output side: check accepted beats, stall in runs
    initial
    begin
        int mode, mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_beat();
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(4, 40);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        int i, len, r, sent;
        logic [pf_pkg::LETTER_W-1:0] l, prev;
        logic fin;
        bit have_prev;

        for (i = 0; i < pf_pkg::CELL_NUM; i++)
            square[i] = '0;

        // reset state: all-zero square, encrypt
        add_letter(5'd5, 1'b0);
        add_letter(5'd0, 1'b1, 2, make_beat(5'd5, 1'b0, 1'b1, 1'b0),
                   make_beat(5'd0, 1'b1, 1'b1, 1'b0));
        add_letter(5'd31, 1'b1, 2, make_beat(5'd31, 1'b0, 1'b1, 1'b0),
                   make_beat(pf_pkg::LET_X, 1'b1, 1'b1, 1'b0));
        add_write(pf_pkg::CFG_DIRECTION, 50'd1);
        add_letter(5'd0, 1'b1, 1, make_beat(5'd0, 1'b1, 1'b0, 1'b1));
        add_letter(5'd31, 1'b0);
        add_letter(5'd31, 1'b1, 2, make_beat(5'd31, 1'b0, 1'b1, 1'b0),
                   make_beat(5'd31, 1'b1, 1'b1, 1'b0));

        key_cells = '{12, 14, 13, 0, 17, 2, 7, 24, 1, 3, 4, 5, 6, 8, 10,
                      11, 15, 16, 18, 19, 20, 21, 22, 23, 25};
        add_write(pf_pkg::CFG_KEY_UPPER, pack_cells(0, 10));
        add_write(pf_pkg::CFG_KEY_MIDDLE, pack_cells(10, 10));
        add_write(pf_pkg::CFG_KEY_BOTTOM, pack_cells(20, 5));
        add_write(pf_pkg::CFG_DIRECTION, 50'd0);
        add_letter(5'd7, 1'b0);
        add_letter(5'd8, 1'b0);
        add_letter(pf_pkg::LET_J, 1'b1);
        add_letter(5'd0, 1'b0);
        add_letter(5'd17, 1'b0);
        add_letter(5'd12, 1'b0);
        add_letter(5'd2, 1'b0);
        add_letter(5'd4, 1'b0);
        add_letter(5'd4, 1'b0);
        add_letter(5'd4, 1'b1);
        add_letter(5'd30, 1'b0);
        add_letter(5'd25, 1'b0);
        // direction flips while a letter is held
        add_letter(5'd2, 1'b0);
        add_write(pf_pkg::CFG_DIRECTION, 50'd1);
        add_letter(5'd7, 1'b1);
        add_letter(pf_pkg::LET_J, 1'b0);
        add_letter(5'd0, 1'b1);
        // every cell the same code
        add_write(pf_pkg::CFG_KEY_UPPER, {pf_pkg::CFG_W{1'b1}});
        add_write(pf_pkg::CFG_KEY_MIDDLE, {pf_pkg::CFG_W{1'b1}});
        add_write(pf_pkg::CFG_KEY_BOTTOM, {pf_pkg::CFG_W{1'b1}});
        add_letter(5'd31, 1'b0);
        add_letter(5'd31, 1'b1);
        add_write(pf_pkg::CFG_DIRECTION, 50'd0);
        add_letter(5'd31, 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].is_write)
                write_reg(directed_rows[n].reg_sel, directed_rows[n].value);
            else
                send_letter(directed_rows[n].letter, directed_rows[n].fin,
                            directed_rows[n].n_typed, directed_rows[n].typed0,
                            directed_rows[n].typed1);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r <= 5)
                shuffle_key(pf_pkg::LET_J);
            else if (r == 6)
                shuffle_key(pf_pkg::LETTER_W'($urandom_range(0, 25)));
            else
                for (i = 0; i < pf_pkg::CELL_NUM; i++)
                    key_cells[i] = (r == 7) ? pf_pkg::LETTER_W'($urandom_range(0, 31)) :
                                   ((r == 8) ? 5'd31 : 5'd0);
            write_reg(pf_pkg::CFG_DIRECTION, pf_pkg::CFG_W'({$urandom, $urandom}));
            write_reg(pf_pkg::CFG_KEY_UPPER, pack_cells(0, 10));
            write_reg(pf_pkg::CFG_KEY_MIDDLE, pack_cells(10, 10));
            write_reg(pf_pkg::CFG_KEY_BOTTOM,
                      pack_cells(20, 5) |
                      (pf_pkg::CFG_W'({$urandom, $urandom}) << pf_pkg::BOTTOM_W));

            len = $urandom_range(12, 36);
            have_prev = 1'b0;
            prev = '0;
            for (i = 0; i < len && sent < RANDOM_ITEMS; i++)
            begin
                r = $urandom_range(0, 19);
                if (r < 3 && have_prev)
                    l = prev;
                else if (r == 3)
                    l = pf_pkg::LETTER_W'($urandom_range(26, 31));
                else if (r == 4)
                    l = pf_pkg::LET_J;
                else
                    l = pf_pkg::LETTER_W'($urandom_range(0, 25));
                fin = ($urandom_range(0, 7) == 0) || (i == len - 1 && $urandom_range(0, 1));
                if (sent == RANDOM_ITEMS / 2)
                begin
                    hold_off();
                    while (expected_beats.size() != 0) @(posedge clk);
                end
                send_letter(l, fin, 0, '0, '0);
                prev = l;
                have_prev = !fin;
                sent++;
            end
        end

        hold_off();
        wait_idle();
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("** playfair_digraph_cipher: PASSED **");
        else
            $display("** playfair_digraph_cipher: FAILED **");
        $finish;
    end

endmodule

>>> playfair_digraph_cipher.f
design/pf_pkg.sv
design/pf_front.sv
design/pf_queue.sv
design/pf_back.sv
design/playfair_digraph_cipher.sv
dv/tb_top.sv
